@@ hdl/pcu_pkg.sv @@
package pcu_pkg;

    localparam int DEF_MAX_POINTS = 1024;
    localparam int DEF_COORD_BITS = 16;

    // fixed field widths of the ports
    localparam int IN_COORD_W  = 16;
    localparam int IDX_W       = 10;
    localparam int CNT_W       = 11;
    localparam int DSQ_W       = 34;
    localparam int PER_W       = 17;
    localparam int CFG_W       = 34;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 8;

    localparam logic [PER_W-1:0] PERIOD_RESET = 17'h10000;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIST_SQ  = 2'd0,
        REG_WRAP     = 2'd1,
        REG_PERIOD_X = 2'd2,
        REG_PERIOD_Y = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [DSQ_W-1:0] distance_squared;
        logic             wrap_enable;
        logic [PER_W-1:0] period_x;
        logic [PER_W-1:0] period_y;
    } cfg_t;

    // control from the sequencer into the distance pipeline
    typedef struct packed {
        logic clear;
        logic live;
    } scan_t;

    // status from the distance pipeline back to the sequencer
    typedef struct packed {
        logic busy;
        logic hit;
    } dist_stat_t;

endpackage

@@ hdl/pcu_store.sv @@
module pcu_store
    import pcu_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_POINTS,
    parameter int AW    = 10,
    parameter int DW    = 2 * DEF_COORD_BITS
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/pcu_dist.sv @@
module pcu_dist
    import pcu_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  scan_t                   scan,
    input  logic [2*COORD_BITS-1:0] rdata,
    input  logic [COORD_BITS-1:0]   qx,
    input  logic [COORD_BITS-1:0]   qy,
    input  cfg_t                    cfg,
    output dist_stat_t              stat
);

    localparam int CB  = COORD_BITS;
    localparam int GW  = (CB > PER_W) ? CB : PER_W;
    localparam int SQW = 2 * GW;
    localparam int SW  = (SQW + 1 > DSQ_W) ? SQW + 1 : DSQ_W;

    // minimum image along one axis: with wrap enabled, |period - d| replaces d when period - d is smaller
    function automatic logic [GW-1:0] fold_gap(
        input logic [CB-1:0]    d,
        input logic [PER_W-1:0] period,
        input logic             wrap
    );
        logic signed [GW:0] alt;
        logic signed [GW:0] ds;
        logic [GW:0]        mag;
        alt = $signed({1'b0, GW'(period)}) - $signed({1'b0, GW'(d)});
        ds  = $signed({1'b0, GW'(d)});
        mag = alt[GW] ? (GW + 1)'(-alt) : alt;
        if (wrap && (alt < ds))
        begin
            return mag[GW-1:0];
        end
        return GW'(d);
    endfunction

    logic [CB-1:0]  px;
    logic [CB-1:0]  py;
    logic           live0_reg;
    logic           live1_reg;
    logic           live2_reg;
    logic           live3_reg;
    logic [CB-1:0]  dx_reg;
    logic [CB-1:0]  dy_reg;
    logic [CB-1:0]  dx_next;
    logic [CB-1:0]  dy_next;
    logic [GW-1:0]  gx_reg;
    logic [GW-1:0]  gy_reg;
    logic [SQW-1:0] sqx_reg;
    logic [SQW-1:0] sqy_reg;
    logic [SQW-1:0] sqx_next;
    logic [SQW-1:0] sqy_next;
    logic           close;
    logic           hit_reg;
    logic           hit_next;

    assign px = rdata[CB-1:0];
    assign py = rdata[2*CB-1:CB];

    assign dx_next  = (qx >= px) ? qx - px : px - qx;
    assign dy_next  = (qy >= py) ? qy - py : py - qy;
    assign sqx_next = gx_reg * gx_reg;
    assign sqy_next = gy_reg * gy_reg;
    assign close    = (SW'(sqx_reg) + SW'(sqy_reg)) < SW'(cfg.distance_squared);

    always_comb
    begin
        hit_next = hit_reg | (live3_reg & close);
        if (scan.clear)
        begin
            hit_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live0_reg <= 1'b0;
            live1_reg <= 1'b0;
            live2_reg <= 1'b0;
            live3_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            live0_reg <= scan.live;
            live1_reg <= live0_reg;
            live2_reg <= live1_reg;
            live3_reg <= live2_reg;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        gx_reg  <= fold_gap(dx_reg, cfg.period_x, cfg.wrap_enable);
        gy_reg  <= fold_gap(dy_reg, cfg.period_y, cfg.wrap_enable);
        sqx_reg <= sqx_next;
        sqy_reg <= sqy_next;
    end

    assign stat.busy = live0_reg | live1_reg | live2_reg | live3_reg;
    assign stat.hit  = hit_reg;

endmodule

@@ hdl/pcu_ctrl.sv @@
module pcu_ctrl
    import pcu_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int AW         = 10
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_TDATA_W-1:0]   s_tdata,
    input  logic [0:0]              s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_TDATA_W-1:0]  m_tdata,
    input  dist_stat_t              stat,
    output scan_t                   scan,
    output logic                    we,
    output logic [AW-1:0]           waddr,
    output logic [2*COORD_BITS-1:0] wdata,
    output logic [AW-1:0]           raddr,
    output logic [COORD_BITS-1:0]   qx,
    output logic [COORD_BITS-1:0]   qy
);

    localparam int CB   = COORD_BITS;
    localparam int XW   = (CB > IN_COORD_W) ? CB : IN_COORD_W;
    localparam int MW   = $clog2(MAX_POINTS + 1);
    localparam int CW   = (MW > CNT_W) ? MW : CNT_W;

    cmd_t            cmd;
    logic [CW-1:0]   idx_ext;
    logic [CW-1:0]   cnt_ext;
    logic [CW-1:0]   cnt_sat;
    logic [XW-1:0]   x_ext;
    logic [XW-1:0]   y_ext;
    logic            accept;
    logic            query_start;
    logic            load_out;

    state_t          state_reg;
    state_t          state_next;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   qidx_reg;
    logic            qexcl_reg;
    logic [CB-1:0]   qx_reg;
    logic [CB-1:0]   qy_reg;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            permitted_reg;

    // tdata: point_index, exclude_valid, coord_x, coord_y, point_count
    assign cmd     = cmd_t'(s_tuser[0]);
    assign idx_ext = CW'(s_tdata[9:0]);
    assign x_ext   = XW'(s_tdata[26:11]);
    assign y_ext   = XW'(s_tdata[42:27]);
    assign cnt_ext = CW'(s_tdata[53:43]);
    assign cnt_sat = (cnt_ext > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : cnt_ext;

    assign accept      = s_tvalid & s_tready;
    assign query_start = accept & (cmd == CMD_QUERY);

    assign we    = accept & (cmd == CMD_WRITE) & (idx_ext < CW'(MAX_POINTS));
    assign waddr = idx_ext[AW-1:0];
    assign wdata = {y_ext[CB-1:0], x_ext[CB-1:0]};
    assign raddr = cnt_reg[AW-1:0];
    assign qx    = qx_reg;
    assign qy    = qy_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_start)
                begin
                    state_next = (cnt_sat == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if ((cnt_reg + CW'(1)) == count_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_tready   = 1'b0;
        scan.live  = 1'b0;
        scan.clear = query_start;
        load_out   = 1'b0;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cnt_next = '0;
            end
            ST_SCAN:
            begin
                // the excluded slot is read but never compared
                scan.live = !(qexcl_reg && (cnt_reg == qidx_reg));
                cnt_next  = cnt_reg + CW'(1);
            end
            ST_DRAIN:
            begin
                cnt_next = cnt_reg;
            end
            ST_DONE:
            begin
                load_out = !out_valid_reg || m_tready;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_start)
        begin
            count_reg <= cnt_sat;
            qidx_reg  <= idx_ext;
            qexcl_reg <= s_tdata[10];
            qx_reg    <= x_ext[CB-1:0];
            qy_reg    <= y_ext[CB-1:0];
        end
        if (load_out)
        begin
            permitted_reg <= !stat.hit;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - 1){1'b0}}, permitted_reg};

`ifndef SYNTHESIS
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> cnt_reg < count_reg)
        else $error("scan address beyond point count");

    a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE |-> !stat.busy)
        else $error("result taken while distance pipeline still busy");

    a_scan_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (query_start && (cnt_sat != '0)) |=> (state_reg == ST_SCAN) && (cnt_reg == '0))
        else $error("query scan did not start at slot zero");
`endif

endmodule

@@ hdl/hard_core_proximity_check_unit.sv @@
// channel | dir | tvalid/tready      | tdata / tuser
// s       | in  | s_tvalid, s_tready | command, point_index, exclude_valid, coords, count
// m       | out | m_tvalid, m_tready | permitted
// cfg     | in  | cfg_we             | cfg_index, cfg_data
//
// a write item gives no result
// a query over n points in use holds the input off while it runs and reads one stored point per cycle,
// then a four-stage distance pipeline drains before the result is given
// reset clears control and configuration; the point memory is not cleared
// a finished result waits in the output register; a new item is taken meanwhile,
// but a following query holds its result until that register is free
module hard_core_proximity_check_unit
    import pcu_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int COORD_BITS = DEF_COORD_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // point_index[9:0], exclude_valid[10], coord_x[26:11], coord_y[42:27],
    // point_count[53:43], zero fill
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // command[0]
    input  logic [0:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // permitted[0], zero fill
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int DW = 2 * COORD_BITS;

    cfg_t          cfg_reg;
    dist_stat_t    stat;
    scan_t         scan;
    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic [AW-1:0] raddr;
    logic [DW-1:0] rdata;
    logic [COORD_BITS-1:0] qx;
    logic [COORD_BITS-1:0] qy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.distance_squared <= '0;
            cfg_reg.wrap_enable      <= 1'b0;
            cfg_reg.period_x         <= PERIOD_RESET;
            cfg_reg.period_y         <= PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_DIST_SQ:  cfg_reg.distance_squared <= cfg_data[DSQ_W-1:0];
                REG_WRAP:     cfg_reg.wrap_enable      <= cfg_data[0];
                REG_PERIOD_X: cfg_reg.period_x         <= cfg_data[PER_W-1:0];
                REG_PERIOD_Y: cfg_reg.period_y         <= cfg_data[PER_W-1:0];
                default:      cfg_reg.wrap_enable      <= cfg_reg.wrap_enable;
            endcase
        end
    end

    pcu_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS),
        .AW         (AW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .stat     (stat),
        .scan     (scan),
        .we       (we),
        .waddr    (waddr),
        .wdata    (wdata),
        .raddr    (raddr),
        .qx       (qx),
        .qy       (qy)
    );

    pcu_store #(
        .DEPTH (MAX_POINTS),
        .AW    (AW),
        .DW    (DW)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    pcu_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .scan  (scan),
        .rdata (rdata),
        .qx    (qx),
        .qy    (qy),
        .cfg   (cfg_reg),
        .stat  (stat)
    );

endmodule

@@ tb/hard_core_proximity_check_unit_tb.sv @@
`timescale 1ns / 1ps

module hard_core_proximity_check_unit_tb;
    import pcu_pkg::*;

    localparam int  SLOTS        = DEF_MAX_POINTS;
    localparam int  CYCLE_LIMIT  = 8000000;
    localparam int  DRAIN_CYCLES = 16;
    localparam int  HOLD_CYCLES  = 800;
    localparam int  PHASE_ITEMS  = 85;
    localparam longint DSQ_MAX   = 64'd8589934592;

    typedef struct {
        cmd_t        cmd;
        logic [9:0]  idx;
        logic        excl;
        logic [15:0] x;
        logic [15:0] y;
        logic [10:0] cnt;
    } pcu_item_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [0:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;

    hard_core_proximity_check_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // configuration as the block should currently hold it
    logic [DSQ_W-1:0] cur_dist_sq  = '0;
    logic             cur_wrap     = 1'b0;
    logic [PER_W-1:0] cur_period_x = PERIOD_RESET;
    logic [PER_W-1:0] cur_period_y = PERIOD_RESET;

    // predictor copy of the point table
    logic [15:0] pt_x [SLOTS];
    logic [15:0] pt_y [SLOTS];

    // stimulus-side view of the table, used to aim queries near stored points
    logic [15:0] gen_x [SLOTS];
    logic [15:0] gen_y [SLOTS];

    pcu_item_t pending_items[$];
    logic      expected_permits[$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    logic in_taken = 1'b0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int  hold_left = 0;

    int  errors = 0;
    int  writes_in = 0;
    int  queries_in = 0;
    int  results_seen = 0;
    int  denied_seen = 0;
    int  settings_run = 0;
    int  cycle_count = 0;
    logic want_permit;

    function automatic longint axis_separation(input longint a, input longint b,
                                               input longint period);
        longint d;
        longint alt;
        d = (a >= b) ? a - b : b - a;
        if (cur_wrap)
        begin
            // minimum image; a negative remainder counts by its magnitude
            alt = period - d;
            if (alt < d)
                d = (alt < 0) ? -alt : alt;
        end
        return d;
    endfunction

    function automatic logic hard_core_clear(input logic [15:0] x, input logic [15:0] y,
                                             input logic excl, input logic [9:0] skip,
                                             input logic [10:0] cnt);
        int     n;
        int     j;
        longint dx;
        longint dy;
        longint limit;
        limit = cur_dist_sq;
        n = (cnt > SLOTS) ? SLOTS : cnt;
        for (j = 0; j < n; j++)
        begin
            if (excl && j == skip)
                continue;
            dx = axis_separation(x, pt_x[j], cur_period_x);
            dy = axis_separation(y, pt_y[j], cur_period_y);
            if (dx * dx + dy * dy < limit)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // input side: take accepted items into the predictor; output side: check each result against it
    always @(posedge clk)
    begin
        in_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            if (cmd_t'(s_tuser[0]) == CMD_WRITE)
            begin
                pt_x[s_tdata[9:0]] = s_tdata[26:11];
                pt_y[s_tdata[9:0]] = s_tdata[42:27];
                writes_in++;
            end
            else
            begin
                expected_permits.push_back(hard_core_clear(s_tdata[26:11], s_tdata[42:27],
                                                           s_tdata[10], s_tdata[9:0],
                                                           s_tdata[53:43]));
                queries_in++;
            end
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_permits.size() == 0)
            begin
                $error("unexpected result item, permitted=%0d", m_tdata[0]);
                errors++;
            end
            else
            begin
                want_permit = expected_permits.pop_front();
                if (m_tdata[0] !== want_permit)
                begin
                    $error("permitted: expected %0d, got %0d", want_permit, m_tdata[0]);
                    errors++;
                end
                results_seen++;
                if (!want_permit)
                    denied_seen++;
            end
        end
    end

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || in_taken)
        begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tuser  <= pending_items[0].cmd;
                s_tdata  <= {2'b00, pending_items[0].cnt, pending_items[0].y,
                             pending_items[0].x, pending_items[0].excl, pending_items[0].idx};
                void'(pending_items.pop_front());
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver, with one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("hard_core_proximity_check_unit_tb: done, errors");
            $finish;
        end
    end

    task automatic write_reg(input reg_idx_t r, input longint value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= value[CFG_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        case (r)
            REG_DIST_SQ:  cur_dist_sq  = value[DSQ_W-1:0];
            REG_WRAP:     cur_wrap     = value[0];
            REG_PERIOD_X: cur_period_x = value[PER_W-1:0];
            REG_PERIOD_Y: cur_period_y = value[PER_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input longint dsq, input longint wrap,
                              input longint px, input longint py);
        write_reg(REG_DIST_SQ, dsq);
        write_reg(REG_WRAP, wrap);
        write_reg(REG_PERIOD_X, px);
        write_reg(REG_PERIOD_Y, py);
        settings_run++;
    endtask

    task automatic push_write(input int idx, input logic [15:0] x, input logic [15:0] y);
        pcu_item_t it;
        it.cmd  = CMD_WRITE;
        it.idx  = idx[9:0];
        it.excl = 1'($urandom_range(1));
        it.x    = x;
        it.y    = y;
        it.cnt  = 11'($urandom_range(2047));
        gen_x[idx] = x;
        gen_y[idx] = y;
        pending_items.push_back(it);
    endtask

    task automatic push_query(input logic [15:0] x, input logic [15:0] y, input logic excl,
                              input int idx, input int cnt);
        pcu_item_t it;
        it.cmd  = CMD_QUERY;
        it.idx  = idx[9:0];
        it.excl = excl;
        it.x    = x;
        it.y    = y;
        it.cnt  = cnt[10:0];
        pending_items.push_back(it);
    endtask

    function automatic logic [15:0] jitter(input logic [15:0] base, input int span);
        int off;
        off = int'($urandom_range(2 * span)) - span;
        return base + off[15:0];
    endfunction

    function automatic logic [15:0] any_coord();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return 16'h0000;
        else if (sel == 1)
            return 16'hffff;
        return 16'($urandom);
    endfunction

    task automatic add_random_item(input int span);
        int   sel;
        int   cnt;
        int   j;
        logic excl;
        logic [15:0] x;
        logic [15:0] y;
        sel = $urandom_range(99);
        if (sel < 35)
        begin
            j = $urandom_range(SLOTS - 1);
            if ($urandom_range(3) == 0)
            begin
                sel = $urandom_range(SLOTS - 1);
                push_write(j, jitter(gen_x[sel], span), jitter(gen_y[sel], span));
            end
            else
                push_write(j, any_coord(), any_coord());
        end
        else
        begin
            // mostly short scans, a few full and saturated ones
            sel = $urandom_range(99);
            if (sel < 75)
                cnt = $urandom_range(64);
            else if (sel < 88)
                cnt = $urandom_range(SLOTS - 1, 65);
            else if (sel < 94)
                cnt = SLOTS;
            else
                cnt = $urandom_range(2047, SLOTS + 1);
            j = $urandom_range(((cnt == 0) ? 1 : ((cnt > SLOTS) ? SLOTS : cnt)) - 1);
            if ($urandom_range(9) < 7)
            begin
                x = jitter(gen_x[j], span);
                y = jitter(gen_y[j], span);
            end
            else
            begin
                x = any_coord();
                y = any_coord();
            end
            excl = 1'($urandom_range(1));
            push_query(x, y, excl, $urandom_range(1) ? j : $urandom_range(SLOTS - 1), cnt);
        end
    endtask

    task automatic run_random(input int n, input int span);
        int k;
        for (k = 0; k < n; k++)
            add_random_item(span);
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || s_tvalid || expected_permits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int k;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: plain distance, radius 100
        set_config(10000, 0, 65536, 65536);
        push_query(16'd0, 16'd0, 1'b0, 0, 0);
        push_write(0, 16'd0, 16'd0);
        push_write(1, 16'hffff, 16'hffff);
        push_write(2, 16'd300, 16'd0);
        push_write(3, 16'd40000, 16'd1234);
        push_query(16'd0, 16'd0, 1'b1, 0, 1);
        push_query(16'd0, 16'd99, 1'b0, 0, 1);
        push_query(16'd0, 16'd100, 1'b0, 0, 1);
        push_query(16'd60, 16'd80, 1'b0, 0, 1);
        push_query(16'hffff, 16'd0, 1'b0, 0, 4);
        // exclusion of a slot beyond the count changes nothing
        push_query(16'd399, 16'd0, 1'b1, 900, 4);
        push_query(16'hffff, 16'hffff, 1'b1, 0, 4);
        push_write(1023, 16'd40000, 16'd1300);
        // fill the rest so any count may be queried
        for (k = 4; k < SLOTS - 1; k++)
            push_write(k, 16'($urandom), 16'($urandom));
        push_query(16'd40000, 16'd1300, 1'b1, 1023, SLOTS);
        push_query(16'd40000, 16'd1300, 1'b1, 3, 2047);
        push_query(16'd40000, 16'd1300, 1'b1, 3, SLOTS - 1);
        push_query(16'd12345, 16'd54321, 1'b0, 0, SLOTS);
        wait_idle();

        send_idle_pct = 31;
        recv_idle_pct = 87;
        set_config(10000, 1, 65536, 65536);
        // corner points are neighbours across the wrap
        push_query(16'd0, 16'd0, 1'b1, 0, 2);
        run_random(PHASE_ITEMS, 150);
        wait_idle();

        set_config(0, 0, 65536, 65536);
        run_random(PHASE_ITEMS, 50);
        wait_idle();

        send_idle_pct = 87;
        recv_idle_pct = 31;
        set_config(DSQ_MAX, 1, 1, 1);
        run_random(PHASE_ITEMS, 100);
        wait_idle();

        set_config(1, 0, 65536, 65536);
        run_random(PHASE_ITEMS, 2);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config($urandom_range(1 << 20), 1, $urandom_range(65536, 1),
                   $urandom_range(65536, 1));
        run_random(PHASE_ITEMS, 1100);
        wait_idle();

        set_config(250000, 1, 4096, 65536);
        hold_req = 1'b1;
        run_random(PHASE_ITEMS, 700);
        wait_idle();

        $display("covered %0d writes and %0d queries under %0d register settings",
                 writes_in, queries_in, settings_run);
        $display("checked %0d results, %0d of them denied, in %0d cycles",
                 results_seen, denied_seen, cycle_count);
        if (errors == 0)
            $display("hard_core_proximity_check_unit_tb: done, clean");
        else
            $display("hard_core_proximity_check_unit_tb: done, errors");
        $finish;
    end

endmodule
